@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge, quiet while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/allist_pkg.sv @@
`default_nettype none

package allist_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  // controller -> datapath
  typedef struct packed {
    logic lat_in;
    logic walk_init;
    logic walk_step;
    logic walk_done;
    logic scan_init;
    logic scan_step;
    logic found;
    logic del_rd;
    logic get_rd;
    logic ins_wr1;
    logic ins_wr2;
    logic del_wr1;
    logic del_wr2;
    logic clr_init;
    logic clr_step;
    logic respond;
    logic reject;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    opcode_t op;
    logic    ins_ok;
    logic    pos_ok;
    logic    scan_hit;
    logic    scan_end;
    logic    scan_pend;
    logic    walk_end;
    logic    link_zero;
    logic    cur_zero;
    logic    clr_last;
    logic    out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/allist_dp.sv @@
`default_nettype none

`include "assert_macros.svh"

module allist_dp import allist_pkg::*; #(
  parameter int MAX_SLOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [6:0]  in_position,
  input  wire logic [31:0] in_entry_value,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_status,
  output logic [31:0]      out_value_out,
  output logic [6:0]       out_list_len
);

  localparam int SW = $clog2(MAX_SLOTS + 1);    // slot index width
  localparam int CW = (SW > 7) ? SW : 7;        // compare width vs 7-bit fields
  localparam int DEPTH = MAX_SLOTS + 1;

  typedef struct packed {
    logic          free;
    logic [SW-1:0] link;
  } node_t;

  node_t         node_mem [DEPTH];
  logic [31:0]   ent_mem  [DEPTH];

  opcode_t       op_r;
  logic [6:0]    pos_r;
  logic [31:0]   val_r;
  logic [CW-1:0] cap_r;
  logic [SW-1:0] len_r;
  logic [SW-1:0] cur_r;
  logic [7:0]    cnt_r;
  logic [SW:0]   scan_r;
  logic [SW-1:0] slot_r;
  logic [SW-1:0] lnk_r;
  logic          cfree_r;
  logic [SW-1:0] obj_r;
  logic [SW-1:0] clr_r;
  node_t         q_r;
  logic [SW-1:0] q_addr_r;
  logic          q_vld_r;
  logic [31:0]   ent_q_r;
  logic          out_valid_r;
  logic          out_status_r;
  logic [31:0]   out_value_r;
  logic [6:0]    out_len_r;

  logic [CW-1:0] ucap_w;
  logic [SW-1:0] ucap_s;
  logic [CW-1:0] pos_ext;
  logic [CW-1:0] len_ext;
  logic          scan_end;
  logic          scan_issue;

  logic          rd_en;
  logic [SW-1:0] rd_addr;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  node_t         wr_data;
  logic          ent_re;
  logic [SW-1:0] ent_raddr;

  logic [SW-1:0] len_nxt;
  logic [CW-1:0] len_nxt_ext;
  logic          out_free;

  // usable capacity: register value clipped to the built slot count
  assign ucap_w  = (cap_r > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : cap_r;
  assign ucap_s  = ucap_w[SW-1:0];
  assign pos_ext = CW'(pos_r);
  assign len_ext = CW'(len_r);

  assign scan_end   = scan_r > {1'b0, ucap_s};
  assign scan_issue = cmd.scan_step && !scan_end;
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    sts           = '0;
    sts.op        = op_r;
    sts.ins_ok    = (pos_ext <= ucap_w) && (len_ext < ucap_w);
    sts.pos_ok    = pos_ext < len_ext;
    sts.scan_hit  = q_vld_r && q_r.free;
    sts.scan_end  = scan_end;
    sts.scan_pend = q_vld_r;
    sts.walk_end  = (cnt_r == '0) || (q_r.link == '0);
    sts.link_zero = q_r.link == '0;
    sts.cur_zero  = cur_r == '0;
    sts.clr_last  = clr_r == SW'(MAX_SLOTS);
    sts.out_free  = out_free;
  end

  // node memory read port; walk steps take the address straight from read data
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    if (cmd.walk_init) begin
      rd_addr = '0;
    end else if (cmd.walk_step || cmd.del_rd) begin
      rd_addr = q_r.link;
    end else if (scan_issue) begin
      rd_addr = scan_r[SW-1:0];
    end else begin
      rd_en = 1'b0;
    end
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = clr_r;
    wr_data = '{free: 1'b1, link: '0};
    if (cmd.ins_wr1) begin
      wr_addr = slot_r;
      wr_data = '{free: 1'b0, link: lnk_r};
    end else if (cmd.ins_wr2) begin
      wr_addr = cur_r;
      wr_data = '{free: cfree_r, link: slot_r};
    end else if (cmd.del_wr1) begin
      wr_addr = obj_r;
    end else if (cmd.del_wr2) begin
      wr_addr = cur_r;
      wr_data = '{free: cfree_r, link: lnk_r};
    end else if (!cmd.clr_step) begin
      wr_en = 1'b0;
    end
  end

  assign ent_re    = cmd.del_rd || cmd.get_rd;
  assign ent_raddr = cmd.del_rd ? q_r.link : cur_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r      <= node_mem[rd_addr];
      q_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_wr1) begin
      ent_mem[slot_r] <= val_r;
    end
    if (ent_re) begin
      ent_q_r <= ent_mem[ent_raddr];
    end
  end

  // length after the operation being reported
  always_comb begin
    len_nxt = len_r;
    if (cmd.respond) begin
      case (op_r)
        OP_INSERT: len_nxt = len_r + SW'(1);
        OP_DELETE: len_nxt = len_r - SW'(1);
        OP_CLEAR:  len_nxt = '0;
        default:   len_nxt = len_r;
      endcase
    end
  end
  assign len_nxt_ext = CW'(len_nxt);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CW'(MAX_SLOTS);
      len_r       <= '0;
      clr_r       <= '0;
      q_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= CW'(cfg_wdata);
      end
      if (cmd.respond || cmd.reject) begin
        len_r       <= len_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.clr_init) begin
        clr_r <= '0;
      end else if (cmd.clr_step) begin
        clr_r <= clr_r + SW'(1);
      end
      q_vld_r <= scan_issue;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.lat_in) begin
      op_r  <= opcode_t'(in_opcode);
      pos_r <= in_position;
      val_r <= in_entry_value;
    end
    if (cmd.scan_init) begin
      scan_r <= (SW + 1)'(1);
    end else if (scan_issue) begin
      scan_r <= scan_r + (SW + 1)'(1);
    end
    if (cmd.found) begin
      slot_r <= q_addr_r;
    end
    if (cmd.walk_init) begin
      cur_r <= '0;
      cnt_r <= (op_r == OP_GET) ? ({1'b0, pos_r} + 8'd1) : {1'b0, pos_r};
    end else if (cmd.walk_step) begin
      cur_r <= q_r.link;
      cnt_r <= cnt_r - 8'd1;
    end
    if (cmd.walk_done) begin
      lnk_r   <= q_r.link;
      cfree_r <= q_r.free;
    end else if (cmd.del_wr1) begin
      lnk_r <= q_r.link;
    end
    if (cmd.del_rd) begin
      obj_r <= q_r.link;
    end
    if (cmd.respond || cmd.reject) begin
      out_status_r <= cmd.reject;
      out_value_r  <= (cmd.respond && (op_r == OP_DELETE || op_r == OP_GET)) ? ent_q_r : '0;
      out_len_r    <= len_nxt_ext[6:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;
  assign out_list_len  = out_len_r;

  `ASSERT_CLK(a_len_bound, len_r <= SW'(MAX_SLOTS), "list length above built capacity")
  `ASSERT_CLK(a_slot_range, cmd.found |-> (q_addr_r != '0) && (q_addr_r <= ucap_s), "slot outside usable range")
  `ASSERT_CLK(a_walk_link, cmd.walk_step |-> q_r.link != '0, "walk followed an end link")

endmodule

`default_nettype wire

@@ rtl/allist_ctrl.sv @@
`default_nettype none

`include "assert_macros.svh"

module allist_ctrl import allist_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [11:0] {
    S_INIT = 12'b0000_0000_0001,
    S_IDLE = 12'b0000_0000_0010,
    S_DEC  = 12'b0000_0000_0100,
    S_SCAN = 12'b0000_0000_1000,
    S_WALK = 12'b0000_0001_0000,
    S_IW1  = 12'b0000_0010_0000,
    S_IW2  = 12'b0000_0100_0000,
    S_DW1  = 12'b0000_1000_0000,
    S_DW2  = 12'b0001_0000_0000,
    S_CLR  = 12'b0010_0000_0000,
    S_RESP = 12'b0100_0000_0000,
    S_REJ  = 12'b1000_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.lat_in = 1'b1;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.op)
          OP_INSERT: begin
            if (sts.ins_ok) begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end else begin
              state_nxt = S_REJ;
            end
          end
          OP_DELETE, OP_GET: begin
            if (sts.pos_ok) begin
              cmd.walk_init = 1'b1;
              state_nxt     = S_WALK;
            end else begin
              state_nxt = S_REJ;
            end
          end
          default: begin
            cmd.clr_init = 1'b1;
            state_nxt    = S_CLR;
          end
        endcase
      end
      S_SCAN: begin
        if (sts.scan_hit) begin
          cmd.found     = 1'b1;
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK;
        end else if (sts.scan_end && !sts.scan_pend) begin
          state_nxt = S_REJ;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_WALK: begin
        if (!sts.walk_end) begin
          cmd.walk_step = 1'b1;
        end else begin
          cmd.walk_done = 1'b1;
          case (sts.op)
            OP_INSERT: state_nxt = S_IW1;
            OP_DELETE: begin
              if (sts.link_zero) begin
                state_nxt = S_REJ;
              end else begin
                cmd.del_rd = 1'b1;
                state_nxt  = S_DW1;
              end
            end
            OP_GET: begin
              if (sts.cur_zero) begin
                state_nxt = S_REJ;
              end else begin
                cmd.get_rd = 1'b1;
                state_nxt  = S_RESP;
              end
            end
            default: state_nxt = S_REJ;
          endcase
        end
      end
      S_IW1: begin
        cmd.ins_wr1 = 1'b1;
        state_nxt   = S_IW2;
      end
      S_IW2: begin
        cmd.ins_wr2 = 1'b1;
        state_nxt   = S_RESP;
      end
      S_DW1: begin
        cmd.del_wr1 = 1'b1;
        state_nxt   = S_DW2;
      end
      S_DW2: begin
        cmd.del_wr2 = 1'b1;
        state_nxt   = S_RESP;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.respond = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_REJ: begin
        if (sts.out_free) begin
          cmd.reject = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_CLK(a_out_free, (cmd.respond || cmd.reject) |-> sts.out_free, "result loaded over a held one")
  `ASSERT_CLK(a_back_idle, (cmd.respond || cmd.reject) |=> state_r == S_IDLE, "no return to idle after result")
  `ASSERT_CLK(a_accept_dec, (in_valid && !in_stall) |=> state_r == S_DEC, "accepted item not decoded")

endmodule

`default_nettype wire

@@ rtl/array_linked_list_engine_top.sv @@
// Array linked list engine: a singly linked list held in a link/free-flag RAM
// and a 32-bit data RAM. Slot 0 is the head; a link of 0 ends the list.
// Input channel (in_valid / in_stall): one transfer carries an opcode
// (insert, delete, get, clear), a list position and a data word.
// Result channel (out_valid / out_stall): one transfer per item with
// status (0 done, 1 rejected), the read or removed word and the new length.
// cfg_we / cfg_wdata set the usable capacity; write only while idle.
// Items are handled one at a time. An insert scans for a free slot (up to
// the usable capacity), then walks to the position; delete and get walk to
// the position; clear sweeps the node RAM; an item rejected at decode goes
// straight to the result. The walk reads one link per cycle through the
// single node RAM port, so a list walk and the free-slot scan set the rate.
// After reset the node RAM is swept with in_stall high; capacity resets to
// MAX_SLOTS. A finished result sits in an output register; while out_stall
// is high it holds and a completed item waits, but the next item is still
// accepted until its own result is due.
`default_nettype none

module array_linked_list_engine_top import allist_pkg::*; #(
  parameter int MAX_SLOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [6:0]  in_position,
  input  wire logic [31:0] in_entry_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_status,
  output logic [31:0]      out_value_out,
  output logic [6:0]       out_list_len,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata
);

  cmd_t cmd;  // sequencer commands
  sts_t sts;  // datapath flags

  // sequencer: decode, scan, walk, link update, result hand-off
  allist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // RAMs, walk/scan registers, length, capacity and output register
  allist_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_opcode      (in_opcode),
    .in_position    (in_position),
    .in_entry_value (in_entry_value),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_value_out  (out_value_out),
    .out_list_len   (out_list_len)
  );

endmodule

`default_nettype wire

@@ bench/allist_result_checker.sv @@
// Watches both channels of the list engine, keeps its own copy of the list
// and checks every result transfer against the oldest outstanding prediction.
module allist_result_checker import allist_pkg::*; #(
  parameter int MAX_SLOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [6:0]  in_position,
  input  wire logic [31:0] in_entry_value,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        out_status,
  input  wire logic [31:0] out_value_out,
  input  wire logic [6:0]  out_list_len,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  output int               fail_count,
  output int               results_owed,
  output logic [6:0]       list_len_now
);

  typedef struct packed {
    logic        status;
    logic [31:0] word;
    logic [6:0]  len;
  } reply_t;

  logic [6:0]  next_slot  [0:MAX_SLOTS];
  logic        slot_empty [0:MAX_SLOTS];
  logic [31:0] slot_word  [0:MAX_SLOTS];
  int          entries;
  logic [6:0]  capacity;
  reply_t      results_due [$];

  // capacity above the built size behaves as the built size
  function automatic int usable_slots();
    return (capacity > MAX_SLOTS) ? MAX_SLOTS : int'(capacity);
  endfunction

  function automatic void empty_list();
    for (int i = 0; i <= MAX_SLOTS; i++) begin
      next_slot[i]  = '0;
      slot_empty[i] = 1'b1;
    end
    entries = 0;
  endfunction

  // slot reached after up to 'steps' links from the head
  function automatic int follow(int steps);
    int here;
    here = 0;
    for (int i = 0; i < steps && i <= MAX_SLOTS; i++) begin
      if (next_slot[here] == '0) break;
      here = int'(next_slot[here]);
    end
    return here;
  endfunction

  function automatic reply_t apply_list_op(opcode_t op, logic [6:0] pos, logic [31:0] val);
    reply_t r;
    int     cap;
    int     slot;
    int     here;
    int     victim;
    r.status = 1'b1;
    r.word   = '0;
    cap      = usable_slots();
    slot     = 0;
    case (op)
      OP_INSERT: begin
        if (pos <= cap && entries < cap) begin
          // lowest free slot among the usable ones only
          for (int i = 1; i <= cap; i++) begin
            if (slot_empty[i]) begin
              slot = i;
              break;
            end
          end
          if (slot != 0) begin
            here             = follow(int'(pos));
            slot_word[slot]  = val;
            slot_empty[slot] = 1'b0;
            next_slot[slot]  = next_slot[here];
            next_slot[here]  = 7'(slot);
            entries++;
            r.status = 1'b0;
          end
        end
      end
      OP_DELETE: begin
        if (pos < entries) begin
          here   = follow(int'(pos));
          victim = int'(next_slot[here]);
          if (victim != 0) begin
            next_slot[here]    = next_slot[victim];
            next_slot[victim]  = '0;
            slot_empty[victim] = 1'b1;
            r.word             = slot_word[victim];
            entries--;
            r.status = 1'b0;
          end
        end
      end
      OP_GET: begin
        if (pos < entries) begin
          here = follow(int'(pos) + 1);
          if (here != 0) begin
            r.word   = slot_word[here];
            r.status = 1'b0;
          end
        end
      end
      default: begin
        empty_list();
        r.status = 1'b0;
      end
    endcase
    r.len = 7'(entries);
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      empty_list();
      capacity   = 7'(MAX_SLOTS);
      fail_count = 0;
      results_due.delete();
    end else begin
      if (cfg_we) capacity = cfg_wdata;
      // result side first: a result never belongs to an item taken at the same edge
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: status %0b value_out %h list_len %0d",
                 out_status, out_value_out, out_list_len);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, out_status);
            fail_count++;
          end
          if (out_value_out !== want.word) begin
            $error("value_out: expected %h, got %h", want.word, out_value_out);
            fail_count++;
          end
          if (out_list_len !== want.len) begin
            $error("list_len: expected %0d, got %0d", want.len, out_list_len);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        results_due.push_back(apply_list_op(opcode_t'(in_opcode), in_position,
                                            in_entry_value));
    end
    results_owed <= results_due.size();
    list_len_now <= 7'(entries);
  end

endmodule

@@ bench/array_linked_list_engine_top_tb.sv @@
// Top of the list engine bench: clock, reset, stimulus and verdict.
// Result checking lives in the checker instance; here we drive and watch for hangs.
module array_linked_list_engine_top_tb;
  import allist_pkg::*;

  localparam int MAX_SLOTS    = 64;
  // longest hold-off of the receiver, well inside the watchdog limit
  localparam int HOLD_CYCLES  = 1500;
  localparam int QUIET_LIMIT  = 5000;
  // wait kept after the last expected result to catch stray transfers
  localparam int DRAIN_CYCLES = 2 * MAX_SLOTS + 20;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic [1:0]  in_opcode      = OP_INSERT;
  logic [6:0]  in_position    = '0;
  logic [31:0] in_entry_value = '0;
  logic        out_stall      = 1'b0;
  logic        cfg_we         = 1'b0;
  logic [6:0]  cfg_wdata      = '0;
  logic        in_stall;
  logic        out_valid;
  logic        out_status;
  logic [31:0] out_value_out;
  logic [6:0]  out_list_len;

  int          fail_count;
  int          results_owed;
  logic [6:0]  list_len_now;

  // chances per cycle, in percent, of the sender idling and the receiver stalling
  int          idle_pct  = 0;
  int          stall_pct = 0;
  // long hold-offs asked for so far; the receiver keeps its own tally
  int          hold_reqs = 0;
  int          quiet     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  array_linked_list_engine_top #(.MAX_SLOTS(MAX_SLOTS)) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_position    (in_position),
    .in_entry_value (in_entry_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_value_out  (out_value_out),
    .out_list_len   (out_list_len),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  allist_result_checker #(.MAX_SLOTS(MAX_SLOTS)) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_position    (in_position),
    .in_entry_value (in_entry_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_value_out  (out_value_out),
    .out_list_len   (out_list_len),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .results_owed   (results_owed),
    .list_len_now   (list_len_now)
  );

  // Receiver: random stall per cycle, or on request one long hold-off so the
  // engine backs up and ends up stalling its input too.
  initial begin
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: too long with no transfer on either channel means a hang.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // One input transfer. Called just after a rising edge; returns at the edge
  // where the item was taken, with valid still high so a back-to-back item
  // needs no drop in between.
  task automatic offer(opcode_t op, logic [6:0] pos, logic [31:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_position    <= pos;
    in_entry_value <= val;
    do @(posedge clk); while (in_stall);
  endtask

  // Capacity is only touched once every outstanding result is back.
  // results_owed is a registered copy of the queue size, hence the first wait.
  task automatic set_capacity(logic [6:0] cap);
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random phase. Mostly positions within the current length,
  // some just past the end, a few anywhere in the 7-bit range.
  task automatic run_phase(logic [6:0] cap, int idle, int stall, int count,
                           int ins_pct, bit squeeze);
    opcode_t    op;
    logic [6:0] pos;
    int         roll;
    set_capacity(cap);
    idle_pct  = idle;
    stall_pct = stall;
    if (squeeze) hold_reqs++;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 1)
        op = OP_CLEAR;
      else if (roll < 1 + ins_pct)
        op = OP_INSERT;
      else if (roll < 1 + ins_pct + (99 - ins_pct) / 2)
        op = OP_DELETE;
      else
        op = OP_GET;
      roll = $urandom_range(99);
      if (roll < 6)
        pos = 7'($urandom_range(127));
      else if (roll < 16)
        pos = list_len_now + 7'($urandom_range(2));
      else if (list_len_now == 0)
        pos = '0;
      else
        pos = 7'($urandom_range(int'(list_len_now) - 1));
      offer(op, pos, $urandom());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty list, extreme words, append past the end, bad positions
    offer(OP_GET,    7'd0,   32'h0);
    offer(OP_DELETE, 7'd0,   32'h0);
    offer(OP_INSERT, 7'd0,   32'h0000_0000);
    offer(OP_INSERT, 7'd0,   32'hFFFF_FFFF);
    offer(OP_INSERT, 7'd5,   32'hA5A5_5A5A);
    offer(OP_INSERT, 7'd65,  32'h0000_0001);
    offer(OP_INSERT, 7'd127, 32'h0000_0002);
    offer(OP_INSERT, 7'd64,  32'h1234_5678);
    offer(OP_GET,    7'd3,   32'h0);
    offer(OP_GET,    7'd4,   32'h0);
    offer(OP_GET,    7'd127, 32'h0);
    offer(OP_DELETE, 7'd1,   32'h0);
    offer(OP_INSERT, 7'd1,   32'hDEAD_BEEF);

    // capacity dropped under the length: high slots stay reachable, list is full
    set_capacity(7'd2);
    offer(OP_INSERT, 7'd0,   32'h0000_0007);
    offer(OP_GET,    7'd2,   32'h0);
    offer(OP_DELETE, 7'd3,   32'h0);
    offer(OP_DELETE, 7'd0,   32'h0);
    offer(OP_INSERT, 7'd0,   32'h5555_AAAA);
    offer(OP_DELETE, 7'd0,   32'h0);
    offer(OP_INSERT, 7'd2,   32'hAAAA_5555);

    // zero capacity rejects every insert; clear still works
    set_capacity(7'd0);
    offer(OP_INSERT, 7'd0,   32'h0000_0001);
    offer(OP_GET,    7'd0,   32'h0);
    offer(OP_CLEAR,  7'd0,   32'h0);
    offer(OP_INSERT, 7'd0,   32'h0000_0003);

    // capacity above the built size acts as the built size
    set_capacity(7'd127);
    offer(OP_INSERT, 7'd64,  32'h8000_0000);
    offer(OP_INSERT, 7'd65,  32'h7FFF_FFFF);

    //        cap      idle stall items ins squeeze
    run_phase(7'd1,    0,   0,    150,  55, 1'b0);
    run_phase(7'd64,   0,   0,    300,  80, 1'b0);
    run_phase(7'd8,    83,  0,    250,  55, 1'b0);
    run_phase(7'd64,   0,   83,   250,  60, 1'b0);
    run_phase(7'd127,  26,  26,   250,  70, 1'b0);
    run_phase(7'd33,   0,   0,    200,  55, 1'b1);
    run_phase(7'd64,   83,  0,    200,  75, 1'b0);
    run_phase(7'd5,    0,   83,   150,  50, 1'b0);
    run_phase(7'd64,   26,  26,   200,  60, 1'b0);

    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    // catch any stray transfer after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
